[rtl/ppc_pkg.sv]
// Shared constants and types for the packet protocol and port counter.
package ppc_pkg;

  localparam int PORT_ENTRIES = 65536;
  localparam int PORT_W       = $clog2(PORT_ENTRIES);
  localparam int CNT_W        = 64;
  localparam int OUT_W        = 64;
  localparam int FLEN_W       = 16;
  localparam int IDX_W        = 16;
  localparam int HDR_KEEP     = 94;
  localparam int CAP_W        = 7;
  localparam int ETH_LEN      = 14;
  localparam int IP_MIN_END   = 34;
  localparam int TCP_HDR_LEN  = 20;
  localparam int UDP_HDR_LEN  = 8;
  localparam int NUM_PROTO    = 4;
  localparam int NUM_FLAGS    = 3;
  localparam int PROTO_IW     = $clog2(NUM_PROTO);
  localparam int FLAG_IW      = $clog2(NUM_FLAGS);
  localparam int RES_DEPTH    = 3;

  // byte offsets within the captured header
  localparam logic [CAP_W-1:0] OFS_ETYPE_HI = CAP_W'(12);
  localparam logic [CAP_W-1:0] OFS_ETYPE_LO = CAP_W'(13);
  localparam logic [CAP_W-1:0] OFS_VER_IHL  = CAP_W'(14);
  localparam logic [CAP_W-1:0] OFS_PROTO    = CAP_W'(23);
  localparam logic [CAP_W-1:0] OFS_DPORT_HI = CAP_W'(2);
  localparam logic [CAP_W-1:0] OFS_DPORT_LO = CAP_W'(3);
  localparam logic [CAP_W-1:0] OFS_TCP_FLAG = CAP_W'(13);

  localparam logic [7:0] ETYPE_HI   = 8'h08;
  localparam logic [7:0] ETYPE_LO   = 8'h00;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;
  localparam logic [7:0] PROTO_ICMP = 8'd1;

  localparam logic [1:0] SLOT_TCP   = 2'd0;
  localparam logic [1:0] SLOT_UDP   = 2'd1;
  localparam logic [1:0] SLOT_ICMP  = 2'd2;
  localparam logic [1:0] SLOT_OTHER = 2'd3;

  localparam logic [1:0] GRP_PROTO = 2'd0;
  localparam logic [1:0] GRP_FLAGS = 2'd1;
  localparam logic [1:0] GRP_PORT  = 2'd2;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // flag counter slots and TCP flag bit positions
  localparam int FLAG_SYN = 0;
  localparam int FLAG_FIN = 1;
  localparam int FLAG_RST = 2;
  localparam int BIT_FIN  = 0;
  localparam int BIT_SYN  = 1;
  localparam int BIT_RST  = 2;

  typedef struct packed {
    logic [CNT_W-1:0] bytes;
    logic [CNT_W-1:0] packets;
  } port_entry_t;

  typedef struct packed {
    logic              ip_ok;
    logic [1:0]        slot;
    logic              port_ok;
    logic [PORT_W-1:0] port;
    logic [FLEN_W-1:0] flen;
    logic [2:0]        flags;
  } fin_t;

  typedef struct packed {
    logic [OUT_W-1:0] packets;
    logic [OUT_W-1:0] bytes;
    logic             ok;
  } result_t;

endpackage

[rtl/packet_protocol_port_counter.sv]
// Top level: header capture, protocol/flag counters and port statistics table.
//
// Takes one word per cycle unless in_stall_o is high, packet bytes and counter reads
// alike. Header fields are picked out as bytes stream past. The protocol and flag
// counters update from the registered packet summary after its last byte, and its
// port entry after a further register stage, through a read-modify-write of the
// port table, a single 65536-entry memory with one write port and two read ports
// (one for updates, one for reads). A read result is registered and then queues in
// a three-entry result buffer, from which it is offered; once the table is cleared,
// input stalls only when that buffer would overflow. After reset the port table is
// cleared one entry per cycle; no input word is accepted during the clear.
module packet_protocol_port_counter import ppc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              kind_i,
  input  logic [7:0]        byte_value_i,
  input  logic              is_last_i,
  input  logic [FLEN_W-1:0] frame_length_i,
  input  logic [1:0]        read_group_i,
  input  logic [IDX_W-1:0]  read_index_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [OUT_W-1:0]  read_packets_o,
  output logic [OUT_W-1:0]  read_bytes_o,
  output logic              read_ok_o
);

  logic in_acc, byte_acc, read_acc;

  // header capture
  logic [CAP_W-1:0] cap_cnt_q, n_d, off, need;
  logic             store;
  logic             e12_q, e12_d, e13_q, e13_d;
  logic [3:0]       ihl_q, ihl_d;
  logic [7:0]       proto_q, proto_d, phi_q, phi_d, plo_q, plo_d;
  logic [2:0]       flags_q, flags_d;
  logic [1:0]       slot;
  fin_t             fin_d, fin_q;
  logic             fin_v_q;

  // counters
  logic [CNT_W-1:0] proto_cnt_q [NUM_PROTO];
  logic [CNT_W-1:0] flag_cnt_q  [NUM_FLAGS];
  logic             tcp_upd;

  // port table
  port_entry_t       port_mem [PORT_ENTRIES];
  port_entry_t       rd_a_q, rd_b_q, upd_wr, fwd_data_q, port_val;
  logic              upd_v_q, fwd_v_q;
  logic [PORT_W-1:0] upd_port_q;
  logic [FLEN_W-1:0] upd_flen_q;
  logic              clr_busy_q;
  logic [PORT_W-1:0] clr_addr_q;

  // read path
  logic             rd_v_q;
  logic [1:0]       rd_grp_q;
  logic [IDX_W-1:0] rd_idx_q;
  result_t          res_d;
  result_t          res_mem [RES_DEPTH];
  logic [1:0]       wp_q, rp_q, res_cnt_q;
  logic             push, pop;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign byte_acc = in_acc && (kind_i == KIND_BYTE);
  assign read_acc = in_acc && (kind_i == KIND_READ);

  assign in_stall_o = clr_busy_q ||
                      ((3'(res_cnt_q) + 3'(rd_v_q)) >= 3'(RES_DEPTH));

  // ---------------- capture ----------------
  assign store = cap_cnt_q < CAP_W'(HDR_KEEP);
  assign n_d   = store ? cap_cnt_q + CAP_W'(1) : cap_cnt_q;
  assign off   = CAP_W'(ETH_LEN) + CAP_W'({ihl_q, 2'b00});

  always_comb begin
    e12_d   = (store && cap_cnt_q == OFS_ETYPE_HI) ? (byte_value_i == ETYPE_HI) : e12_q;
    e13_d   = (store && cap_cnt_q == OFS_ETYPE_LO) ? (byte_value_i == ETYPE_LO) : e13_q;
    ihl_d   = (store && cap_cnt_q == OFS_VER_IHL)  ? byte_value_i[3:0] : ihl_q;
    proto_d = (store && cap_cnt_q == OFS_PROTO)    ? byte_value_i : proto_q;
    phi_d   = (store && cap_cnt_q == off + OFS_DPORT_HI) ? byte_value_i : phi_q;
    plo_d   = (store && cap_cnt_q == off + OFS_DPORT_LO) ? byte_value_i : plo_q;
    flags_d = (store && cap_cnt_q == off + OFS_TCP_FLAG) ? byte_value_i[2:0] : flags_q;
  end

  always_comb begin
    case (proto_d)
      PROTO_TCP:  slot = SLOT_TCP;
      PROTO_UDP:  slot = SLOT_UDP;
      PROTO_ICMP: slot = SLOT_ICMP;
      default:    slot = SLOT_OTHER;
    endcase
  end

  assign need = off + ((slot == SLOT_TCP) ? CAP_W'(TCP_HDR_LEN) : CAP_W'(UDP_HDR_LEN));

  always_comb begin
    fin_d.ip_ok   = (n_d >= CAP_W'(IP_MIN_END)) && e12_d && e13_d;
    fin_d.slot    = slot;
    fin_d.port_ok = fin_d.ip_ok && (slot == SLOT_TCP || slot == SLOT_UDP) && (need <= n_d);
    fin_d.port    = PORT_W'({phi_d, plo_d});
    fin_d.flen    = frame_length_i;
    fin_d.flags   = flags_d;
  end

  always_ff @(posedge clk_i) begin
    if (byte_acc) begin
      e12_q   <= e12_d;
      e13_q   <= e13_d;
      ihl_q   <= ihl_d;
      proto_q <= proto_d;
      phi_q   <= phi_d;
      plo_q   <= plo_d;
      flags_q <= flags_d;
    end
    if (byte_acc && is_last_i) begin
      fin_q <= fin_d;
    end
  end

  // ---------------- counters ----------------
  assign tcp_upd = fin_v_q && fin_q.port_ok && (fin_q.slot == SLOT_TCP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_cnt_q <= '0;
      fin_v_q   <= 1'b0;
      upd_v_q   <= 1'b0;
      fwd_v_q   <= 1'b0;
      rd_v_q    <= 1'b0;
      for (int i = 0; i < NUM_PROTO; i++) proto_cnt_q[i] <= '0;
      for (int i = 0; i < NUM_FLAGS; i++) flag_cnt_q[i] <= '0;
    end else begin
      if (byte_acc) begin
        cap_cnt_q <= is_last_i ? '0 : n_d;
      end
      fin_v_q <= byte_acc && is_last_i;
      upd_v_q <= fin_v_q && fin_q.port_ok;
      fwd_v_q <= upd_v_q && (upd_port_q == PORT_W'(read_index_i));
      rd_v_q  <= read_acc;
      for (int i = 0; i < NUM_PROTO; i++) begin
        if (fin_v_q && fin_q.ip_ok && fin_q.slot == PROTO_IW'(i)) begin
          proto_cnt_q[i] <= proto_cnt_q[i] + CNT_W'(1);
        end
      end
      if (tcp_upd && fin_q.flags[BIT_SYN]) flag_cnt_q[FLAG_SYN] <= flag_cnt_q[FLAG_SYN] + CNT_W'(1);
      if (tcp_upd && fin_q.flags[BIT_FIN]) flag_cnt_q[FLAG_FIN] <= flag_cnt_q[FLAG_FIN] + CNT_W'(1);
      if (tcp_upd && fin_q.flags[BIT_RST]) flag_cnt_q[FLAG_RST] <= flag_cnt_q[FLAG_RST] + CNT_W'(1);
    end
  end

  // ---------------- port table ----------------
  always_comb begin
    upd_wr.packets = rd_a_q.packets + CNT_W'(1);
    upd_wr.bytes   = rd_a_q.bytes + CNT_W'(upd_flen_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + PORT_W'(1);
      if (clr_addr_q == '1) clr_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      port_mem[clr_addr_q] <= '0;
    end else if (upd_v_q) begin
      port_mem[upd_port_q] <= upd_wr;
    end
    rd_a_q <= port_mem[fin_q.port];
    rd_b_q <= port_mem[PORT_W'(read_index_i)];
  end

  always_ff @(posedge clk_i) begin
    upd_port_q <= fin_q.port;
    upd_flen_q <= fin_q.flen;
    fwd_data_q <= upd_wr;
    if (read_acc) begin
      rd_grp_q <= read_group_i;
      rd_idx_q <= read_index_i;
    end
  end

  // ---------------- read path ----------------
  // a write landing this cycle or at the read's sampling edge is forwarded
  always_comb begin
    if (upd_v_q && upd_port_q == PORT_W'(rd_idx_q)) begin
      port_val = upd_wr;
    end else if (fwd_v_q) begin
      port_val = fwd_data_q;
    end else begin
      port_val = rd_b_q;
    end
  end

  always_comb begin
    res_d = '0;
    case (rd_grp_q)
      GRP_PROTO: begin
        if (rd_idx_q < IDX_W'(NUM_PROTO)) begin
          res_d.ok      = 1'b1;
          res_d.packets = OUT_W'(proto_cnt_q[rd_idx_q[PROTO_IW-1:0]]);
        end
      end
      GRP_FLAGS: begin
        if (rd_idx_q < IDX_W'(NUM_FLAGS)) begin
          res_d.ok      = 1'b1;
          res_d.packets = OUT_W'(flag_cnt_q[rd_idx_q[FLAG_IW-1:0]]);
        end
      end
      GRP_PORT: begin
        res_d.ok      = 1'b1;
        res_d.packets = OUT_W'(port_val.packets);
        res_d.bytes   = OUT_W'(port_val.bytes);
      end
      default: res_d = '0;
    endcase
  end

  assign push = rd_v_q;
  assign pop  = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      rp_q      <= '0;
      res_cnt_q <= '0;
    end else begin
      if (push) wp_q <= (wp_q == 2'(RES_DEPTH - 1)) ? '0 : wp_q + 2'd1;
      if (pop)  rp_q <= (rp_q == 2'(RES_DEPTH - 1)) ? '0 : rp_q + 2'd1;
      res_cnt_q <= res_cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) res_mem[wp_q] <= res_d;
  end

  assign out_valid_o    = res_cnt_q != '0;
  assign read_packets_o = res_mem[rp_q].packets;
  assign read_bytes_o   = res_mem[rp_q].bytes;
  assign read_ok_o      = res_mem[rp_q].ok;

endmodule

[rtl/ppc_checker.sv]
// Port-level checks for the packet protocol and port counter, bound to the top.
module ppc_checker import ppc_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [OUT_W-1:0]  read_packets_o,
  input logic [OUT_W-1:0]  read_bytes_o,
  input logic              read_ok_o
);

  // result word held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(read_packets_o) && $stable(read_bytes_o) && $stable(read_ok_o))
    else $error("stalled result word changed");

  // a rejected selector reports empty counts
  a_bad_sel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !read_ok_o |-> read_packets_o == '0 && read_bytes_o == '0)
    else $error("rejected read carries nonzero counts");

  // table clear pass holds off input right after reset
  a_clear_stall: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> in_stall_o && !out_valid_o)
    else $error("input taken during table clear");

endmodule

bind packet_protocol_port_counter ppc_checker u_ppc_checker (.*);

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Random packet and counter-read testbench for packet_protocol_port_counter with a built-in predictor.
module tb_top;
  import ppc_pkg::*;

  localparam int IDLE_PCT     = 27;
  localparam int HOLD_CYCLES  = 400;
  localparam int WATCHDOG_MAX = 200000;
  localparam int TAIL_CYCLES  = 20;
  localparam int RANDOM_WORDS = 1300;
  localparam int MIN_READS    = 60;
  localparam int CALM_FROM    = 500;
  localparam int CALM_TO      = 800;
  localparam int HOLD_AT      = 900;
  localparam int DRAIN_AT     = 1100;
  localparam int HOLD_BURST   = 20;

  localparam logic [1:0] GRP_NONE = 2'd3;
  localparam logic [15:0] HOT_PORTS [8] = '{16'd0, 16'd80, 16'd443, 16'd53,
                                            16'hFFFF, 16'h8000, 16'h00FF, 16'h5A5A};

  typedef enum int {
    PK_TCP, PK_UDP, PK_ICMP, PK_OTHER, PK_NOT_IP, PK_SHORT,
    PK_SMALL_IHL, PK_TRUNC, PK_LONG, PK_MAX_IHL, PK_COUNT
  } pkt_shape_e;

  typedef struct {
    logic              kind;
    logic [7:0]        value;
    logic              last;
    logic [FLEN_W-1:0] flen;
    logic [1:0]        grp;
    logic [IDX_W-1:0]  idx;
    bit                drain_first;
    bit                hold_here;
    bit                calm;
  } word_t;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              in_valid_i     = 1'b0;
  logic              in_stall_o;
  logic              kind_i         = KIND_BYTE;
  logic [7:0]        byte_value_i   = '0;
  logic              is_last_i      = 1'b0;
  logic [FLEN_W-1:0] frame_length_i = '0;
  logic [1:0]        read_group_i   = GRP_PROTO;
  logic [IDX_W-1:0]  read_index_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i    = 1'b0;
  logic [OUT_W-1:0]  read_packets_o;
  logic [OUT_W-1:0]  read_bytes_o;
  logic              read_ok_o;

  packet_protocol_port_counter DUT (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predicted block state
  bit [7:0]         hdr_bytes [HDR_KEEP];
  int unsigned      hdr_fill;
  bit [CNT_W-1:0]   proto_pkts [NUM_PROTO];
  bit [CNT_W-1:0]   flag_pkts [NUM_FLAGS];
  bit [CNT_W-1:0]   port_pkts [PORT_ENTRIES];
  bit [CNT_W-1:0]   port_octets [PORT_ENTRIES];
  result_t          read_replies_due [$];

  word_t            words_to_send [$];
  word_t            next_word;
  result_t          due;
  bit               marking_calm;
  int               reads_queued;
  int               total_words;
  int               words_taken;
  int               mismatches;
  int               stuck_cycles;
  int               hold_left;
  bit               hold_started;
  bit               word_taken;
  logic             calm_now = 1'b0;
  logic             hold_req = 1'b0;

  task automatic count_packet(input logic [FLEN_W-1:0] flen);
    int unsigned off, need;
    logic [1:0] slot;
    logic [PORT_W-1:0] port;
    logic [7:0] tcp_flags;
    if (hdr_fill < ETH_LEN || hdr_bytes[OFS_ETYPE_HI] != ETYPE_HI ||
        hdr_bytes[OFS_ETYPE_LO] != ETYPE_LO) return;
    if (hdr_fill < IP_MIN_END) return;
    case (hdr_bytes[OFS_PROTO])
      PROTO_TCP:  slot = SLOT_TCP;
      PROTO_UDP:  slot = SLOT_UDP;
      PROTO_ICMP: slot = SLOT_ICMP;
      default:    slot = SLOT_OTHER;
    endcase
    proto_pkts[slot] += 1;
    if (slot != SLOT_TCP && slot != SLOT_UDP) return;
    // IHL below 5 is taken as is
    off  = ETH_LEN + 4 * hdr_bytes[OFS_VER_IHL][3:0];
    need = off + ((slot == SLOT_TCP) ? TCP_HDR_LEN : UDP_HDR_LEN);
    if (need > hdr_fill || need > HDR_KEEP) return;
    port = {hdr_bytes[off + OFS_DPORT_HI], hdr_bytes[off + OFS_DPORT_LO]};
    port_pkts[port]   += 1;
    port_octets[port] += flen;
    if (slot == SLOT_TCP) begin
      tcp_flags = hdr_bytes[off + OFS_TCP_FLAG];
      if (tcp_flags[BIT_SYN]) flag_pkts[FLAG_SYN] += 1;
      if (tcp_flags[BIT_FIN]) flag_pkts[FLAG_FIN] += 1;
      if (tcp_flags[BIT_RST]) flag_pkts[FLAG_RST] += 1;
    end
  endtask

  task automatic take_word(input logic kind, input logic [7:0] value, input logic last,
                           input logic [FLEN_W-1:0] flen, input logic [1:0] grp,
                           input logic [IDX_W-1:0] idx);
    result_t reply;
    if (kind == KIND_BYTE) begin
      if (hdr_fill < HDR_KEEP) begin
        hdr_bytes[hdr_fill] = value;
        hdr_fill++;
      end
      if (last) begin
        count_packet(flen);
        hdr_fill = 0;
      end
    end else begin
      reply = '0;
      case (grp)
        GRP_PROTO: if (idx < NUM_PROTO) begin
          reply.packets = proto_pkts[idx];
          reply.ok      = 1'b1;
        end
        GRP_FLAGS: if (idx < NUM_FLAGS) begin
          reply.packets = flag_pkts[idx];
          reply.ok      = 1'b1;
        end
        GRP_PORT: begin
          reply.packets = port_pkts[idx];
          reply.bytes   = port_octets[idx];
          reply.ok      = 1'b1;
        end
        default: ;
      endcase
      read_replies_due.push_back(reply);
    end
  endtask

  task automatic queue_word(input logic kind, input logic [7:0] value, input logic last,
                            input logic [FLEN_W-1:0] flen, input logic [1:0] grp,
                            input logic [IDX_W-1:0] idx);
    word_t w;
    w.kind        = kind;
    w.value       = value;
    w.last        = last;
    w.flen        = flen;
    w.grp         = grp;
    w.idx         = idx;
    w.drain_first = 1'b0;
    w.hold_here   = 1'b0;
    w.calm        = marking_calm;
    words_to_send.push_back(w);
  endtask

  task automatic queue_read(input logic [1:0] grp, input logic [IDX_W-1:0] idx);
    queue_word(KIND_READ, 8'($urandom()), 1'($urandom()), FLEN_W'($urandom()), grp, idx);
    reads_queued++;
  endtask

  task automatic queue_random_read();
    int r;
    r = $urandom_range(99);
    if (r < 40)
      queue_read(GRP_PORT, ($urandom_range(99) < 70) ? HOT_PORTS[$urandom_range(7)]
                                                     : IDX_W'($urandom()));
    else if (r < 65)
      queue_read(GRP_PROTO, ($urandom_range(9) == 0) ? IDX_W'($urandom())
                                                     : IDX_W'($urandom_range(NUM_PROTO - 1)));
    else if (r < 85)
      queue_read(GRP_FLAGS, ($urandom_range(9) == 0) ? IDX_W'($urandom())
                                                     : IDX_W'($urandom_range(NUM_FLAGS - 1)));
    else
      queue_read(GRP_NONE, IDX_W'($urandom()));
  endtask

  function automatic pkt_shape_e pick_shape();
    int r;
    r = $urandom_range(99);
    if (r < 30) return PK_TCP;
    if (r < 55) return PK_UDP;
    if (r < 60) return PK_ICMP;
    if (r < 65) return PK_OTHER;
    if (r < 73) return PK_NOT_IP;
    if (r < 81) return PK_SHORT;
    if (r < 86) return PK_SMALL_IHL;
    if (r < 92) return PK_TRUNC;
    if (r < 97) return PK_LONG;
    return PK_MAX_IHL;
  endfunction

  task automatic queue_packet(input pkt_shape_e shape);
    logic [7:0]        pkt [$];
    int                len, ihl, off, hlen, r;
    logic [7:0]        proto;
    logic [15:0]       dport, etype;
    logic [FLEN_W-1:0] flen;
    ihl   = 5;
    len   = IP_MIN_END;
    etype = {ETYPE_HI, ETYPE_LO};
    proto = $urandom_range(1) ? PROTO_TCP : PROTO_UDP;
    dport = ($urandom_range(99) < 70) ? HOT_PORTS[$urandom_range(7)] : 16'($urandom());
    r     = $urandom_range(9);
    flen  = (r == 0) ? '0 : (r == 1) ? '1 : FLEN_W'($urandom());
    case (shape)
      PK_TCP: begin
        proto = PROTO_TCP;
        ihl   = $urandom_range(5, 7);
        len   = ETH_LEN + 4 * ihl + TCP_HDR_LEN + $urandom_range(8);
      end
      PK_UDP: begin
        proto = PROTO_UDP;
        ihl   = $urandom_range(5, 7);
        len   = ETH_LEN + 4 * ihl + UDP_HDR_LEN + $urandom_range(8);
      end
      PK_ICMP: begin
        proto = PROTO_ICMP;
        len   = $urandom_range(IP_MIN_END, IP_MIN_END + 10);
      end
      PK_OTHER: begin
        do proto = 8'($urandom());
        while (proto inside {PROTO_TCP, PROTO_UDP, PROTO_ICMP});
        len = $urandom_range(IP_MIN_END, IP_MIN_END + 10);
      end
      PK_NOT_IP: begin
        etype = 16'($urandom());
        case ($urandom_range(2))
          0: etype[15:8] = ETYPE_HI;
          1: etype[7:0]  = ETYPE_LO;
          default: ;
        endcase
        if (etype == {ETYPE_HI, ETYPE_LO}) etype[0] = 1'b1;
        len = $urandom_range(1, 60);
      end
      PK_SHORT: len = $urandom_range(1, IP_MIN_END - 1);
      PK_SMALL_IHL: begin
        ihl = $urandom_range(4);
        len = $urandom_range(IP_MIN_END, 60);
      end
      PK_TRUNC: begin
        ihl  = $urandom_range(5, 15);
        hlen = (proto == PROTO_TCP) ? TCP_HDR_LEN : UDP_HDR_LEN;
        len  = $urandom_range(IP_MIN_END, ETH_LEN + 4 * ihl + hlen - 1);
      end
      PK_LONG: begin
        ihl = $urandom_range(5, 15);
        len = $urandom_range(HDR_KEEP + 1, HDR_KEEP + 30);
      end
      PK_MAX_IHL: begin
        proto = PROTO_TCP;
        ihl   = 15;
        len   = $urandom_range(HDR_KEEP, HDR_KEEP + 4);
      end
      default: ;
    endcase
    repeat ((len > HDR_KEEP) ? len : HDR_KEEP) pkt.push_back(8'($urandom()));
    off = ETH_LEN + 4 * ihl;
    pkt[off + OFS_DPORT_HI] = dport[15:8];
    pkt[off + OFS_DPORT_LO] = dport[7:0];
    pkt[OFS_ETYPE_HI]       = etype[15:8];
    pkt[OFS_ETYPE_LO]       = etype[7:0];
    pkt[OFS_VER_IHL]        = {4'($urandom()), 4'(ihl)};
    pkt[OFS_PROTO]          = proto;
    for (int i = 0; i < len; i++) begin
      // reads slipped into a packet must not disturb capture
      if ($urandom_range(99) < 3) queue_random_read();
      queue_word(KIND_BYTE, pkt[i], i == len - 1, (i == len - 1) ? flen : FLEN_W'($urandom()),
                 2'($urandom()), IDX_W'($urandom()));
    end
  endtask

  // sender
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || word_taken)) begin
      if (words_to_send.size() != 0 &&
          !(words_to_send[0].drain_first && read_replies_due.size() != 0) &&
          (words_to_send[0].calm || $urandom_range(99) >= IDLE_PCT)) begin
        next_word = words_to_send.pop_front();
        in_valid_i     <= 1'b1;
        kind_i         <= next_word.kind;
        byte_value_i   <= next_word.value;
        is_last_i      <= next_word.last;
        frame_length_i <= next_word.flen;
        read_group_i   <= next_word.grp;
        read_index_i   <= next_word.idx;
        calm_now       <= next_word.calm;
        if (next_word.hold_here) hold_req <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall
  always @(negedge clk_i) begin
    if (hold_req && !hold_started) begin
      hold_started = 1'b1;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm_now && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin
    word_taken = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (read_replies_due.size() == 0) begin
          $error("result word with no read pending");
          mismatches++;
        end else begin
          due = read_replies_due.pop_front();
          if (read_packets_o !== due.packets) begin
            $error("read_packets: expected %0d, got %0d", due.packets, read_packets_o);
            mismatches++;
          end
          if (read_bytes_o !== due.bytes) begin
            $error("read_bytes: expected %0d, got %0d", due.bytes, read_bytes_o);
            mismatches++;
          end
          if (read_ok_o !== due.ok) begin
            $error("read_ok: expected %0d, got %0d", due.ok, read_ok_o);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        word_taken = 1'b1;
        words_taken++;
        take_word(kind_i, byte_value_i, is_last_i, frame_length_i, read_group_i, read_index_i);
      end
      if (word_taken || (out_valid_o && !out_stall_i)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_MAX) begin
          $display("simulation failed");
          $finish;
        end
      end
    end
  end

  initial begin
    int base, done, first;
    bit hold_done, drain_done;
    // counters at reset, bad selectors, two lone last bytes
    for (int i = 0; i < NUM_PROTO; i++) queue_read(GRP_PROTO, IDX_W'(i));
    for (int i = 0; i < NUM_FLAGS; i++) queue_read(GRP_FLAGS, IDX_W'(i));
    queue_read(GRP_PROTO, IDX_W'(NUM_PROTO));
    queue_read(GRP_PROTO, '1);
    queue_read(GRP_FLAGS, IDX_W'(NUM_FLAGS));
    queue_read(GRP_PORT, '0);
    queue_read(GRP_PORT, '1);
    queue_read(GRP_NONE, '0);
    queue_read(GRP_NONE, '1);
    queue_word(KIND_BYTE, 8'hFF, 1'b1, '1, GRP_PORT, '1);
    queue_word(KIND_BYTE, 8'h00, 1'b1, '0, GRP_NONE, '0);

    base = words_to_send.size();
    for (int n = 0; words_to_send.size() - base < RANDOM_WORDS || reads_queued < MIN_READS;
         n++) begin
      done         = words_to_send.size() - base;
      marking_calm = (done >= CALM_FROM && done < CALM_TO);
      if (!hold_done && done >= HOLD_AT) begin
        hold_done = 1'b1;
        first     = words_to_send.size();
        repeat (HOLD_BURST) queue_random_read();
        words_to_send[first].hold_here = 1'b1;
      end else if (!drain_done && done >= DRAIN_AT) begin
        drain_done = 1'b1;
        queue_random_read();
        words_to_send[words_to_send.size() - 1].drain_first = 1'b1;
      end else if (n < PK_COUNT) begin
        queue_packet(pkt_shape_e'(n));
      end else if ($urandom_range(99) < 65) begin
        queue_packet(pick_shape());
      end else begin
        repeat ($urandom_range(1, 4)) queue_random_read();
      end
    end
    marking_calm = 1'b0;
    for (int i = 0; i < NUM_PROTO; i++) queue_read(GRP_PROTO, IDX_W'(i));
    for (int i = 0; i < NUM_FLAGS; i++) queue_read(GRP_FLAGS, IDX_W'(i));
    for (int i = 0; i < 8; i++) queue_read(GRP_PORT, HOT_PORTS[i]);
    total_words = words_to_send.size();

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (words_taken < total_words || read_replies_due.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
